FILE: rtl/crd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crd_pkg;

  // Frame layout and arithmetic constants
  localparam int unsigned PayloadKeep = 22;
  localparam int unsigned StoreIdxW   = 5;
  localparam int unsigned MinLength   = 24;
  localparam logic [7:0]  CrcPoly     = 8'hD5;
  localparam int unsigned RawW        = 11;
  localparam int unsigned ChanW       = 4;
  localparam int unsigned PercentW    = 16;
  localparam int unsigned ScaleW      = 16;
  localparam int unsigned BitBufW     = 18;
  localparam int unsigned BitCntW     = 5;

  // Configuration register indexes
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgAddrW-1:0] CfgSyncValue   = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgFrameType   = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgPulseMin    = 2'd2;
  localparam logic [CfgAddrW-1:0] CfgPercentScal = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_UNPACK,
    ST_MUL,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/crd_scaler.sv
`timescale 1ns / 1ps
`default_nettype none

module crd_scaler
  import crd_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [RawW-1:0]            raw_i,
  input  wire logic [RawW-1:0]            pulse_min_i,
  input  wire logic [ScaleW-1:0]          scale_i,
  output      logic signed [PercentW-1:0] percent_o
);

  localparam int unsigned DiffW = RawW + 1;
  localparam int unsigned ProdW = DiffW + ScaleW + 1;
  localparam int unsigned QW    = ProdW - 8;

  logic signed [DiffW-1:0]    diff;
  logic signed [ScaleW:0]     gain;
  logic signed [ProdW-1:0]    prod_d, prod_q;
  logic signed [QW-1:0]       quot;

  // Offset and gain, one product registered per channel
  assign diff   = $signed({1'b0, raw_i}) - $signed({1'b0, pulse_min_i});
  assign gain   = $signed({1'b0, scale_i});
  assign prod_d = ProdW'(diff) * ProdW'(gain);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // Floor divide by 256, then clamp to the Q8.8 range
  assign quot = QW'(prod_q >>> 8);

  always_comb begin
    if (quot > QW'(32767)) begin
      percent_o = 16'sh7FFF;
    end else if (quot < -QW'(32768)) begin
      percent_o = 16'sh8000;
    end else begin
      percent_o = quot[PercentW-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/crsf_rc_channel_deframer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Receives serial bytes of CRSF-style RC channels frames, one item per byte, with tuser
// flagging the first byte after a line-idle gap. Bytes covered by the CRC keep the
// input stalled while a single shift-and-xor unit runs the CRC-8 (poly 0xD5) one bit
// a cycle. On a matching CRC byte the stored payload is unpacked into CHANNEL_COUNT
// 11-bit channels. Each channel takes one or two byte loads into a bit buffer, one
// extract, one registered multiply and one output write. A good frame holds the input
// until the final channel is loaded into the output register, which waits while
// results are stalled. Each result carries the channel index, the raw value and a
// saturated Q8.8 percent floor((raw - pulse_minimum) * percent_scale / 256); tlast
// marks the final channel. Frames with a bad sync, length, type or CRC give no result.

module crsf_rc_channel_deframer_top
  import crd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 64,
  parameter int unsigned CHANNEL_COUNT   = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input bytes
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  input  wire logic [7:0]          s_axis_tdata_i,  // [7:0] rx_byte
  input  wire logic                s_axis_tuser_i,  // [0] frame_start
  // Channel results
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [3:0] channel_index, [14:4] raw_value, [30:15] scaled_percent, [31] zero
  output      logic [31:0]         m_axis_tdata_o,
  output      logic                m_axis_tlast_o,  // last_channel
  // Configuration writes
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES);

  // Configuration registers
  logic [7:0]        sync_value_q;
  logic [7:0]        frame_type_q;
  logic [RawW-1:0]   pulse_min_q;
  logic [ScaleW-1:0] percent_scale_q;

  // Parser and sequencer state
  state_e            state_q, state_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [7:0]        len_q, len_d;
  logic [7:0]        crc_q, crc_d;
  logic              alive_q, alive_d;
  logic [2:0]        crc_cnt_q, crc_cnt_d;
  logic [BitBufW-1:0] buf_q, buf_d;
  logic [BitCntW-1:0] bits_q, bits_d;
  logic [StoreIdxW-1:0] idx_q, idx_d;
  logic [ChanW-1:0]  ch_q, ch_d;
  logic [RawW-1:0]   raw_q, raw_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [ChanW-1:0]  out_ch_q;
  logic [RawW-1:0]   out_raw_q;
  logic [PercentW-1:0] out_pct_q;
  logic              out_last_q;
  logic              out_load;

  logic [7:0]        payload_q [PayloadKeep];
  logic              store_we;
  logic [PosW-1:0]   store_off;
  logic [7:0]        fetch_byte_q;
  logic              in_acc;
  logic              last_ch;
  logic signed [PercentW-1:0] percent;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign store_off       = pos_q - PosW'(3);
  assign last_ch         = (ch_q == ChanW'(CHANNEL_COUNT - 1));

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_value_q    <= 8'd200;
      frame_type_q    <= 8'd22;
      pulse_min_q     <= 11'd172;
      percent_scale_q <= 16'd3999;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        CfgSyncValue:   sync_value_q    <= cfg_data_i[7:0];
        CfgFrameType:   frame_type_q    <= cfg_data_i[7:0];
        CfgPulseMin:    pulse_min_q     <= cfg_data_i[RawW-1:0];
        CfgPercentScal: percent_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: byte parsing, bit-serial CRC, channel unpacking
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    len_d       = len_q;
    crc_d       = crc_q;
    alive_d     = alive_q;
    crc_cnt_d   = crc_cnt_q;
    buf_d       = buf_q;
    bits_d      = bits_q;
    idx_d       = idx_q;
    ch_d        = ch_q;
    raw_d       = raw_q;
    store_we    = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready_i;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i) begin
            // Restart on a flagged byte
            crc_d   = 8'd0;
            len_d   = 8'd0;
            alive_d = (s_axis_tdata_i == sync_value_q);
            pos_d   = (s_axis_tdata_i == sync_value_q) ? PosW'(1) : '0;
          end else if (alive_q) begin
            if (pos_q != '1) begin
              pos_d = pos_q + PosW'(1);
            end
            if (pos_q == PosW'(1)) begin
              len_d = s_axis_tdata_i;
              if (s_axis_tdata_i < 8'(MinLength) ||
                  ({1'b0, s_axis_tdata_i} + 9'd2) > 9'(MAX_FRAME_BYTES)) begin
                alive_d = 1'b0;
              end
            end else if (pos_q == PosW'(2)) begin
              if (s_axis_tdata_i != frame_type_q) begin
                alive_d = 1'b0;
              end else begin
                crc_d     = crc_q ^ s_axis_tdata_i;
                crc_cnt_d = '0;
                state_d   = ST_CRC;
              end
            end else if (8'(pos_q) <= len_q) begin
              store_we  = (store_off < PosW'(PayloadKeep));
              crc_d     = crc_q ^ s_axis_tdata_i;
              crc_cnt_d = '0;
              state_d   = ST_CRC;
            end else begin
              // CRC byte closes the frame
              alive_d = 1'b0;
              pos_d   = '0;
              if (s_axis_tdata_i == crc_q) begin
                buf_d   = '0;
                bits_d  = '0;
                idx_d   = '0;
                ch_d    = '0;
                state_d = ST_UNPACK;
              end
            end
          end
        end
      end

      ST_CRC: begin
        // Shift one bit per cycle through the polynomial
        crc_d     = crc_q[7] ? ({crc_q[6:0], 1'b0} ^ CrcPoly) : {crc_q[6:0], 1'b0};
        crc_cnt_d = crc_cnt_q + 3'd1;
        if (crc_cnt_q == 3'd7) begin
          state_d = ST_IDLE;
        end
      end

      ST_UNPACK: begin
        if (bits_q < BitCntW'(RawW)) begin
          buf_d  = buf_q | (BitBufW'(fetch_byte_q) << bits_q);
          bits_d = bits_q + BitCntW'(8);
          idx_d  = idx_q + StoreIdxW'(1);
        end else begin
          raw_d   = buf_q[RawW-1:0];
          buf_d   = buf_q >> RawW;
          bits_d  = bits_q - BitCntW'(RawW);
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          ch_d        = ch_q + ChanW'(1);
          state_d     = last_ch ? ST_IDLE : ST_UNPACK;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      len_q       <= '0;
      crc_q       <= '0;
      alive_q     <= 1'b0;
      crc_cnt_q   <= '0;
      bits_q      <= '0;
      idx_q       <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      crc_q       <= crc_d;
      alive_q     <= alive_d;
      crc_cnt_q   <= crc_cnt_d;
      bits_q      <= bits_d;
      idx_q       <= idx_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload store, registered fetch at the next unpack index, result registers
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    raw_q <= raw_d;
    if (store_we) begin
      payload_q[store_off[StoreIdxW-1:0]] <= s_axis_tdata_i;
    end
    if (idx_d < StoreIdxW'(PayloadKeep)) begin
      fetch_byte_q <= payload_q[idx_d];
    end else begin
      fetch_byte_q <= 8'd0;
    end
    if (out_load) begin
      out_ch_q   <= ch_q;
      out_raw_q  <= raw_q;
      out_pct_q  <= percent;
      out_last_q <= last_ch;
    end
  end

  crd_scaler u_scaler (
    .clk_i       (clk_i),
    .en_i        (state_q == ST_MUL),
    .raw_i       (raw_q),
    .pulse_min_i (pulse_min_q),
    .scale_i     (percent_scale_q),
    .percent_o   (percent)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_pct_q, out_raw_q, out_ch_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

FILE: sim/crsf_rc_channel_deframer_top_tb.sv
`timescale 1ns / 1ps

module crsf_rc_channel_deframer_top_tb;
  import crd_pkg::*;

  localparam int unsigned FrameMax     = 64;
  localparam int unsigned NumChannels  = 16;
  localparam int          SettleCycles = 120;
  localparam int          PhaseBytes   = 40;
  localparam int          CycleLimit   = 200000;
  localparam int          ReportLimit  = 10;

  typedef struct packed {
    logic [ChanW-1:0]           chan;
    logic [RawW-1:0]            raw;
    logic signed [PercentW-1:0] pct;
    logic                       is_last;
  } channel_t;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;
  typedef enum int {SEQ_GOOD, SEQ_BAD_CRC, SEQ_CUT, SEQ_NOISE, SEQ_BAD_HEADER} seq_kind_e;
  typedef enum int {HDR_SYNC, HDR_SHORT, HDR_LONG, HDR_TYPE} hdr_fault_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i = '0;  // [7:0] rx_byte
  logic                s_axis_tuser_i = 1'b0;  // [0] frame_start
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // [3:0] channel_index, [14:4] raw_value, [30:15] scaled_percent, [31] zero
  logic [31:0]         m_axis_tdata_o;
  logic                m_axis_tlast_o;  // last_channel
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Register copies, reset values
  logic [7:0]        sync_cfg  = 8'd200;
  logic [7:0]        type_cfg  = 8'd22;
  logic [RawW-1:0]   pmin_cfg  = 11'd172;
  logic [ScaleW-1:0] scale_cfg = 16'd3999;

  // Deframer state as seen from outside
  int         pos_acc = 0;
  int         len_acc = 0;
  logic [7:0] crc_acc = '0;
  logic       alive = 1'b0;
  logic [7:0] payload_copy [PayloadKeep];

  channel_t pending_channels [$];

  int  parsed_bytes = 0;
  int  bytes_sent = 0;
  int  frames_ok = 0;
  int  results_checked = 0;
  int  reg_writes = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  sender_steady = 1'b0;
  bit  receiver_steady = 1'b0;

  crsf_rc_channel_deframer_top #(
    .MAX_FRAME_BYTES(FrameMax),
    .CHANNEL_COUNT  (NumChannels)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // CRC-8, one byte, MSB first
  function automatic logic [7:0] crc8_d5(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // Q8.8 percent, floored, saturated to 16 bits
  function automatic logic signed [PercentW-1:0] percent_of(input logic [RawW-1:0] raw);
    longint prod;
    longint q;
    prod = (longint'(raw) - longint'(pmin_cfg)) * longint'(scale_cfg);
    q = prod >>> 8;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[PercentW-1:0];
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Advance the parser by one byte; queue the channels of a frame whose CRC matches
  function automatic void deframe_byte(input logic [7:0] b, input logic start);
    int p;
    logic [8*PayloadKeep-1:0] packed_bits;
    channel_t res;
    if (start) begin
      crc_acc = '0;
      len_acc = 0;
      alive = (b == sync_cfg);
      pos_acc = alive ? 1 : 0;
      parsed_bytes++;
      return;
    end
    if (!alive) return;
    parsed_bytes++;
    p = pos_acc;
    if (pos_acc < 63) pos_acc++;
    if (p == 1) begin
      len_acc = b;
      if (len_acc < MinLength || len_acc + 2 > FrameMax) alive = 1'b0;
      return;
    end
    if (p == 2) begin
      if (b != type_cfg) alive = 1'b0;
      else crc_acc = crc8_d5(crc_acc, b);
      return;
    end
    if (p <= len_acc) begin
      // bytes past the kept payload still feed the CRC
      if (p - 3 < PayloadKeep) payload_copy[p - 3] = b;
      crc_acc = crc8_d5(crc_acc, b);
      return;
    end
    alive = 1'b0;
    pos_acc = 0;
    if (b != crc_acc) return;
    frames_ok++;
    for (int i = 0; i < PayloadKeep; i++) packed_bits[8*i +: 8] = payload_copy[i];
    for (int ch = 0; ch < NumChannels; ch++) begin
      res.chan    = 4'(ch);
      res.raw     = packed_bits[RawW*ch +: RawW];
      res.pct     = percent_of(res.raw);
      res.is_last = (ch == NumChannels - 1);
      pending_channels.push_back(res);
    end
  endfunction

  // Offer one byte after a random gap, hold until accepted
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= start;
    do @(posedge clk_i); while (!s_axis_tready_o);
    deframe_byte(b, start);
    bytes_sent++;
  endtask

  // Drop valid, wait for every queued channel, then let the block settle
  task automatic wait_drained(input int extra);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_channels.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (addr)
      CfgSyncValue:   sync_cfg  = data[7:0];
      CfgFrameType:   type_cfg  = data[7:0];
      CfgPulseMin:    pmin_cfg  = data[RawW-1:0];
      CfgPercentScal: scale_cfg = data[ScaleW-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Build a frame with the current sync and type; optionally spoil the CRC or cut it short
  task automatic send_frame(input int len, input fill_e fill, input bit bad_crc, input int cut);
    logic [7:0] frame_q [$];
    logic [7:0] crc;
    logic [7:0] pb;
    int         count;
    crc = 8'h00;
    frame_q.push_back(sync_cfg);
    frame_q.push_back(8'(len));
    frame_q.push_back(type_cfg);
    crc = crc8_d5(crc, type_cfg);
    for (int i = 3; i <= len; i++) begin
      case (fill)
        FILL_ZERO: pb = 8'h00;
        FILL_ONES: pb = 8'hFF;
        default:   pb = rand_byte();
      endcase
      frame_q.push_back(pb);
      crc = crc8_d5(crc, pb);
    end
    if (bad_crc) crc = crc ^ (8'h01 << $urandom_range(0, 7));
    frame_q.push_back(crc);
    count = (cut > 0 && cut < frame_q.size()) ? cut : frame_q.size();
    for (int i = 0; i < count; i++) send_byte(frame_q[i], i == 0);
  endtask

  // Short sequences that must all be rejected
  task automatic test_reject_cases();
    // unflagged bytes with no frame open
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);
    // wrong sync byte
    send_byte(~sync_cfg, 1'b1);
    send_byte(8'(MinLength), 1'b0);
    send_byte(type_cfg, 1'b0);
    // length just below the minimum, and zero
    send_byte(sync_cfg, 1'b1);
    send_byte(8'(MinLength - 1), 1'b0);
    send_byte(type_cfg, 1'b0);
    send_byte(sync_cfg, 1'b1);
    send_byte(8'h00, 1'b0);
    // length just above the maximum, and all ones
    send_byte(sync_cfg, 1'b1);
    send_byte(8'(FrameMax - 1), 1'b0);
    send_byte(type_cfg, 1'b0);
    send_byte(sync_cfg, 1'b1);
    send_byte(8'hFF, 1'b0);
    // wrong frame type
    send_byte(sync_cfg, 1'b1);
    send_byte(8'(MinLength), 1'b0);
    send_byte(~type_cfg, 1'b0);
    send_byte(8'h00, 1'b0);
    // frame start in mid-frame restarts parsing
    send_byte(sync_cfg, 1'b1);
    send_byte(8'd30, 1'b0);
    send_byte(type_cfg, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(sync_cfg, 1'b1);
    send_byte(8'(MinLength - 1), 1'b0);
  endtask

  // One good frame, then good frames mixed with damaged ones and line noise
  task automatic test_random_frames(input int first_len, input fill_e first_fill,
                                    input int phase_bytes);
    int         bytes0;
    int         r;
    int         len;
    seq_kind_e  kind;
    hdr_fault_e hdr;
    logic [7:0] flip;
    bytes0 = parsed_bytes;
    send_frame(first_len, first_fill, 1'b0, 0);
    while (parsed_bytes - bytes0 < phase_bytes) begin
      sender_steady   = ($urandom_range(0, 3) == 0);
      receiver_steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r < 6) len = MinLength;
      else if (r < 9) len = $urandom_range(MinLength + 1, 40);
      else len = FrameMax - 2;
      r = $urandom_range(0, 9);
      kind = (r < 6) ? SEQ_GOOD : seq_kind_e'(r - 5);
      flip = 8'($urandom_range(1, 255));
      case (kind)
        SEQ_GOOD: begin
          send_frame(len, FILL_RANDOM, 1'b0, 0);
          // bytes after the CRC byte are ignored
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) send_byte(rand_byte(), 1'b0);
          end
          if ($urandom_range(0, 3) == 0) wait_drained(0);
        end
        SEQ_BAD_CRC: send_frame(len, FILL_RANDOM, 1'b1, 0);
        SEQ_CUT:     send_frame(len, FILL_RANDOM, 1'b0, $urandom_range(1, len + 1));
        SEQ_NOISE: begin
          repeat ($urandom_range(1, 4)) send_byte(rand_byte(), $urandom_range(0, 3) == 0);
        end
        default: begin
          hdr = hdr_fault_e'($urandom_range(0, 3));
          send_byte((hdr == HDR_SYNC) ? (sync_cfg ^ flip) : sync_cfg, 1'b1);
          case (hdr)
            HDR_SHORT: send_byte(8'($urandom_range(0, MinLength - 1)), 1'b0);
            HDR_LONG:  send_byte(8'($urandom_range(FrameMax - 1, 255)), 1'b0);
            default:   send_byte(8'(MinLength), 1'b0);
          endcase
          send_byte((hdr == HDR_TYPE) ? (type_cfg ^ flip) : type_cfg, 1'b0);
          send_byte(rand_byte(), 1'b0);
        end
      endcase
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
  endtask

  // Retune every register while idle, then run frames under the new setting
  task automatic test_settings(input logic [7:0] sync_v, input logic [7:0] type_v,
                               input logic [RawW-1:0] pmin_v, input logic [ScaleW-1:0] scale_v,
                               input int first_len, input fill_e first_fill,
                               input int phase_bytes);
    wait_drained(SettleCycles);
    write_reg(CfgSyncValue, {8'h00, sync_v});
    write_reg(CfgFrameType, {8'h00, type_v});
    write_reg(CfgPulseMin, {5'b0, pmin_v});
    write_reg(CfgPercentScal, scale_v);
    test_random_frames(first_len, first_fill, phase_bytes);
  endtask

  // Receiver: random stall after each item, none while steady
  always @(posedge clk_i) begin : drive_ready
    int stall;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      stall = receiver_steady ? 0 : $urandom_range(0, 10);
      stall_left      <= stall;
      m_axis_tready_i <= (stall == 0);
    end else if (!m_axis_tready_i) begin
      if (stall_left <= 1) begin
        m_axis_tready_i <= 1'b1;
        stall_left      <= 0;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  // Compare each channel item with the oldest queued channel
  always @(posedge clk_i) begin : check_channels
    channel_t want;
    channel_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.chan    = m_axis_tdata_o[3:0];
      got.raw     = m_axis_tdata_o[14:4];
      got.pct     = m_axis_tdata_o[30:15];
      got.is_last = m_axis_tlast_o;
      if (pending_channels.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("Unexpected channel: ch %0d raw %0d pct %0d last %0b",
                   got.chan, got.raw, got.pct, got.is_last);
        end
      end else begin
        want = pending_channels.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("Channel mismatch: expected ch %0d raw %0d pct %0d last %0b",
                     want.chan, want.raw, want.pct, want.is_last);
            $display("                  got      ch %0d raw %0d pct %0d last %0b",
                     got.chan, got.raw, got.pct, got.is_last);
          end
        end
      end
    end
  end

  // Hang guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timed out with %0d channels outstanding", pending_channels.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reject_cases();
    test_random_frames(MinLength, FILL_ZERO, PhaseBytes);
    // pulse minimum 0 with full gain saturates high
    test_settings(8'h00, 8'h00, 11'd0, 16'hFFFF, MinLength, FILL_ONES, 0);
    // pulse minimum at the top saturates low
    test_settings(8'hFF, 8'hFF, 11'h7FF, 16'hFFFF, MinLength, FILL_ZERO, 0);
    test_settings(rand_byte(), rand_byte(), 11'($urandom_range(0, 2047)),
                  16'($urandom_range(0, 65535)), MinLength, FILL_RANDOM, 0);
    wait_drained(SettleCycles);
    $display("Sent %0d bytes: reject cases, good, damaged and cut frames, line noise;",
             bytes_sent);
    $display("checked %0d channels from %0d frames across %0d register writes.",
             results_checked, frames_ok, reg_writes);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
